### design/rsil_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsil_pkg
// Types and constants shared by the range set cells and the top level.
// ----------------------------------------------------------------------------
package rsil_pkg;

  localparam int unsigned CpW          = 21;
  localparam int unsigned DefMaxRanges = 16;
  localparam logic [CpW-1:0] EndLimit  = 21'h1FFFFF;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef struct packed {
    logic           opcode;
    logic [CpW-1:0] code_point;
    logic [CpW-1:0] span_length;
  } req_t;

  typedef struct packed {
    logic           found;
    logic [3:0]     range_slot;
    logic [CpW-1:0] offset_in_range;
    logic           table_full;
    logic [4:0]     ranges_used;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_e;

  // Per-cell command for each cycle of the shift pass.
  typedef struct packed {
    logic shift_up;    // take the left neighbor's entry
    logic shift_down;  // take the right neighbor's entry
    logic load;        // take the merged or new range
  } cell_ctl_t;

endpackage

### design/range_set_insert_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_set_insert_lookup
// Sorted set of disjoint code-point ranges with union insert and lookup.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  req     | in        | req_valid/ready  | req_t (opcode, code_point, length)
//  rsp     | out       | rsp_valid/ready  | rsp_t (found .. ranges_used)
//
// One request at a time. The controller scans entries with one comparator a
// cycle. An insert then either opens a slot by moving the whole tail up at
// once and loading the new range in the next cycle, or closes absorbed gaps
// one position per cycle. The response register holds until taken; a new
// request is accepted once the previous response is out. Reset clears the
// entry count and control; cell contents start undefined.
// ----------------------------------------------------------------------------
module range_set_insert_lookup
  import rsil_pkg::*;
#(
  parameter int unsigned MAX_RANGES = DefMaxRanges
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  input  logic rsp_ready_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  localparam int unsigned IdxW = $clog2(MAX_RANGES);
  localparam int unsigned CntW = $clog2(MAX_RANGES + 1);

  state_e state_q, state_d;

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] ptr_q, ptr_d;      // scan pointer
  logic [CntW-1:0] first_q, first_d;  // i: first entry reaching the start
  logic            have_first_q, have_first_d;
  logic [CntW-1:0] moves_q, moves_d;  // shift steps left to do
  logic            op_q;
  logic [CpW-1:0]  s_q, e_q, cp_q;
  logic [CpW-1:0]  new_s_q, new_s_d, new_e_q, new_e_d;
  logic            mode_up_q, mode_up_d;  // open a slot vs. compact
  rsp_t            rsp_q, rsp_d;
  logic            rsp_v_q, rsp_v_d;

  logic [CpW-1:0] st [MAX_RANGES];
  logic [CpW-1:0] en [MAX_RANGES];
  cell_ctl_t      ctl [MAX_RANGES];

  // Cell row: each entry talks only to its neighbors.
  for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
    localparam int unsigned L = (g == 0) ? 0 : g - 1;
    localparam int unsigned R = (g == MAX_RANGES - 1) ? g : g + 1;
    rsil_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl[g]),
      .left_start_i (st[L]),
      .left_end_i   (en[L]),
      .right_start_i(st[R]),
      .right_end_i  (en[R]),
      .load_start_i (new_s_q),
      .load_end_i   (new_e_q),
      .start_o      (st[g]),
      .end_o        (en[g])
    );
  end

  // Request end clipped to the code space.
  logic [CpW:0]   sum_w;
  logic [CpW-1:0] e_clip;
  assign sum_w  = {1'b0, req_i.code_point} + {1'b0, req_i.span_length};
  assign e_clip = (sum_w > {1'b0, EndLimit}) ? EndLimit : sum_w[CpW-1:0];

  logic [IdxW-1:0] pidx;
  logic [CpW-1:0]  cs, ce;
  logic            in_range;
  assign pidx = ptr_q[IdxW-1:0];
  assign cs   = st[pidx];
  assign ce   = en[pidx];
  assign in_range = ptr_q < count_q;

  assign req_ready_o = (state_q == ST_IDLE) && !rsp_v_q;
  assign rsp_valid_o = rsp_v_q;
  assign rsp_o       = rsp_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (req_valid_i && req_ready_o) state_d = ST_SCAN;
      ST_SCAN: begin
        if (op_q == OP_LOOKUP) begin
          if (!in_range || (cp_q >= cs && cp_q < ce)) state_d = ST_DONE;
        end else if (e_q <= s_q) begin
          state_d = ST_DONE;
        end else if (!in_range || (have_first_q && cs > e_q)) begin
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: if (moves_q == '0) state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    count_d      = count_q;
    ptr_d        = ptr_q;
    first_d      = first_q;
    have_first_d = have_first_q;
    moves_d      = moves_q;
    new_s_d      = new_s_q;
    new_e_d      = new_e_q;
    mode_up_d    = mode_up_q;
    rsp_d        = rsp_q;
    rsp_v_d      = rsp_v_q;
    for (int c = 0; c < MAX_RANGES; c++) ctl[c] = '0;

    if (rsp_v_q && rsp_ready_i) rsp_v_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        ptr_d        = '0;
        have_first_d = 1'b0;
        // Hold the waiting response; clear only when a new request comes in.
        if (req_valid_i && req_ready_o) rsp_d = '0;
      end
      ST_SCAN: begin
        if (op_q == OP_LOOKUP) begin
          if (in_range && cp_q >= cs && cp_q < ce) begin
            rsp_d.found           = 1'b1;
            rsp_d.range_slot      = 4'(ptr_q);
            rsp_d.offset_in_range = cp_q - cs;
          end
          ptr_d = ptr_q + 1'b1;
        end else if (e_q > s_q) begin
          if (in_range && !have_first_q && ce >= s_q) begin
            // First touching candidate: may still not overlap.
            have_first_d = 1'b1;
            first_d      = ptr_q;
            new_s_d      = (cs < s_q) ? cs : s_q;
            new_e_d      = (ce > e_q) ? ce : e_q;
            if (cs > e_q) begin
              // Gap before this entry: plain insert here.
              new_s_d   = s_q;
              new_e_d   = e_q;
              mode_up_d = 1'b1;
              moves_d   = count_q - ptr_q;
            end
            ptr_d = ptr_q + 1'b1;
          end else if (in_range && !have_first_q) begin
            // Entry ends before the new start: skip it.
            ptr_d = ptr_q + 1'b1;
          end else if (in_range && have_first_q && cs <= e_q) begin
            if (ce > new_e_q) new_e_d = ce;
            ptr_d = ptr_q + 1'b1;
          end else if (!have_first_q) begin
            // Reached the end without a candidate: append.
            first_d   = count_q;
            new_s_d   = s_q;
            new_e_d   = e_q;
            mode_up_d = 1'b1;
            moves_d   = '0;
          end
          // Leaving the scan with a merge group first .. ptr-1.
          if (have_first_q && !mode_up_q && (!in_range || cs > e_q)) begin
            moves_d = ptr_q - first_q - 1'b1;
          end
        end
      end
      ST_SHIFT: begin
        if (mode_up_q) begin
          if (count_q == CntW'(MAX_RANGES)) begin
            rsp_d.table_full = 1'b1;
            moves_d          = '0;
          end else if (moves_q != '0) begin
            for (int c = 1; c < MAX_RANGES; c++)
              if (CntW'(c) > first_q && CntW'(c) <= count_q) ctl[c].shift_up = 1'b1;
            moves_d = '0;
          end else begin
            ctl[first_q[IdxW-1:0]].load = 1'b1;
            count_d = count_q + 1'b1;
          end
        end else begin
          ctl[first_q[IdxW-1:0]].load = 1'b1;
          if (moves_q != '0) begin
            // Advance entries after the group down by one, one step a cycle.
            for (int c = 0; c < MAX_RANGES - 1; c++)
              if (CntW'(c) > first_q && CntW'(c) < count_q - 1'b1)
                ctl[c].shift_down = 1'b1;
            count_d = count_q - 1'b1;
            moves_d = moves_q - 1'b1;
          end
        end
      end
      ST_DONE: begin
        rsp_d.ranges_used = 5'(count_q);
        rsp_v_d           = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      rsp_v_q      <= 1'b0;
      ptr_q        <= '0;
      have_first_q <= 1'b0;
      moves_q      <= '0;
      mode_up_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      rsp_v_q      <= rsp_v_d;
      ptr_q        <= ptr_d;
      have_first_q <= have_first_d;
      moves_q      <= moves_d;
      mode_up_q    <= (state_q == ST_IDLE) ? 1'b0 : mode_up_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    new_s_q <= new_s_d;
    new_e_q <= new_e_d;
    rsp_q   <= rsp_d;
    if (req_valid_i && req_ready_o) begin
      op_q <= req_i.opcode;
      s_q  <= req_i.code_point;
      cp_q <= req_i.code_point;
      e_q  <= e_clip;
    end
  end

  // Count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_RANGES)) else $error("entry count overflow");

  // A lookup never changes the count.
  a_lookup_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && op_q == OP_LOOKUP) |=> $stable(count_q))
    else $error("lookup changed count");

  // No new request while a response waits.
  a_one_outstanding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_v_q |-> !req_ready_o) else $error("request taken with response pending");

endmodule

### design/rsil_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsil_cell
// One table entry: holds a range start and end, shifts with its neighbors.
// ----------------------------------------------------------------------------
module rsil_cell
  import rsil_pkg::*;
(
  input  logic           clk_i,
  input  cell_ctl_t      ctl_i,
  input  logic [CpW-1:0] left_start_i,
  input  logic [CpW-1:0] left_end_i,
  input  logic [CpW-1:0] right_start_i,
  input  logic [CpW-1:0] right_end_i,
  input  logic [CpW-1:0] load_start_i,
  input  logic [CpW-1:0] load_end_i,
  output logic [CpW-1:0] start_o,
  output logic [CpW-1:0] end_o
);

  logic [CpW-1:0] start_q, end_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      start_q <= load_start_i;
      end_q   <= load_end_i;
    end else if (ctl_i.shift_up) begin
      start_q <= left_start_i;
      end_q   <= left_end_i;
    end else if (ctl_i.shift_down) begin
      start_q <= right_start_i;
      end_q   <= right_end_i;
    end
  end

  assign start_o = start_q;
  assign end_o   = end_q;

endmodule

### bench/tb_range_set_insert_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_set_insert_lookup
// Drives insert and lookup requests into the range set with random idling on
// both channels. A scoreboard keeps its own sorted range table, predicts each
// response and checks the responses in order, field by field.
// ----------------------------------------------------------------------------
module tb_range_set_insert_lookup;
  import rsil_pkg::*;

  localparam int unsigned SlotCount = DefMaxRanges;
  localparam int unsigned WatchLimit = 20000;

  // Shadow range table: applies each accepted request, queues the response.
  class range_scoreboard;
    logic [CpW-1:0] starts[SlotCount];
    logic [CpW-1:0] lengths[SlotCount];
    int unsigned held;
    rsp_t pending[$];
    int unsigned errors;

    function new();
      held = 0;
      errors = 0;
    endfunction

    function bit merge_range(logic [CpW-1:0] s_in, logic [CpW-1:0] len_in);
      int unsigned s, e, first, last, gone, j;
      s = s_in;
      e = s_in + len_in;
      if (e > EndLimit) e = EndLimit;
      if (e <= s) return 1'b0;
      first = 0;
      while (first < held && starts[first] + lengths[first] < s) first++;
      last = first;
      while (last < held && starts[last] <= e) last++;
      if (last == first) begin
        if (held >= SlotCount) return 1'b1;
        for (j = held; j > first; j--) begin
          starts[j] = starts[j-1];
          lengths[j] = lengths[j-1];
        end
        starts[first] = CpW'(s);
        lengths[first] = CpW'(e - s);
        held++;
        return 1'b0;
      end
      if (starts[first] < s) s = starts[first];
      if (starts[last-1] + lengths[last-1] > e) e = starts[last-1] + lengths[last-1];
      starts[first] = CpW'(s);
      lengths[first] = CpW'(e - s);
      gone = last - first - 1;
      for (j = first + 1; j + gone < held; j++) begin
        starts[j] = starts[j+gone];
        lengths[j] = lengths[j+gone];
      end
      held -= gone;
      return 1'b0;
    endfunction

    function void note_request(req_t r);
      rsp_t p;
      p = '0;
      if (r.opcode == OP_INSERT) begin
        p.table_full = merge_range(r.code_point, r.span_length);
      end else begin
        for (int unsigned i = 0; i < held; i++) begin
          if (r.code_point >= starts[i] && r.code_point - starts[i] < lengths[i]) begin
            p.found = 1'b1;
            p.range_slot = i[3:0];
            p.offset_in_range = r.code_point - starts[i];
            break;
          end
        end
      end
      p.ranges_used = held[4:0];
      pending.insert(pending.size(), p);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_response(rsp_t r);
      rsp_t w;
      if (pending.size() == 0) begin
        report("unexpected response", 32'(r.ranges_used), 32'd0);
        return;
      end
      w = pending.pop_front();
      if (r.found !== w.found) report("found", 32'(r.found), 32'(w.found));
      if (r.range_slot !== w.range_slot)
        report("range_slot", 32'(r.range_slot), 32'(w.range_slot));
      if (r.offset_in_range !== w.offset_in_range)
        report("offset_in_range", 32'(r.offset_in_range), 32'(w.offset_in_range));
      if (r.table_full !== w.table_full)
        report("table_full", 32'(r.table_full), 32'(w.table_full));
      if (r.ranges_used !== w.ranges_used)
        report("ranges_used", 32'(r.ranges_used), 32'(w.ranges_used));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  req_t req_i = '0;
  logic rsp_ready_i = 1'b0;
  logic rsp_valid_o;
  rsp_t rsp_o;

  range_scoreboard board = new();
  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 46;
  int unsigned quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  range_set_insert_lookup dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(req_valid_i), .req_ready_o(req_ready_o), .req_i(req_i),
    .rsp_ready_i(rsp_ready_i), .rsp_valid_o(rsp_valid_o), .rsp_o(rsp_o)
  );

  // Note requests and check responses at the edge where each handshake fires.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_valid_i && req_ready_o) board.note_request(req_i);
      if (rsp_valid_o && rsp_ready_i) board.check_response(rsp_o);
    end
  end

  // Receiver: stall at random, one new decision per edge.
  always @(posedge clk_i) begin
    rsp_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: count edges with no handshake on either channel.
  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchLimit) begin
      $display("tb_range_set_insert_lookup: done, errors");
      $finish;
    end
  end

  // Present one request, hold it until accepted, then idle at random.
  task send_request(logic op, logic [CpW-1:0] cp, logic [CpW-1:0] len);
    req_t r;
    r.opcode = op;
    r.code_point = cp;
    r.span_length = len;
    req_valid_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (!req_ready_o);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  // Mostly small ranges in a narrow window so merges and full tables happen;
  // sometimes the whole code space and odd lengths.
  task send_random();
    logic [CpW-1:0] cp, len;
    logic op;
    op = $urandom_range(99) < 45;
    case ($urandom_range(9))
      0: begin
        cp = CpW'($urandom);
        len = CpW'($urandom);
      end
      1, 2: begin
        cp = CpW'($urandom_range(1114111));
        len = CpW'($urandom_range(1114112, 1));
      end
      default: begin
        cp = CpW'($urandom_range(600));
        len = CpW'($urandom_range(12, 1));
      end
    endcase
    send_request(op, cp, len);
  endtask

  task drain();
    req_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table lookup, empty inserts, clipping, merges, full table.
    send_request(OP_LOOKUP, 21'd0, 21'd0);
    send_request(OP_INSERT, 21'd5, 21'd0);
    send_request(OP_INSERT, 21'h1FFFFF, 21'd1);
    send_request(OP_INSERT, 21'h1FFFF0, 21'h1FFFFF);
    send_request(OP_LOOKUP, 21'h1FFFFE, 21'd0);
    send_request(OP_INSERT, 21'd100, 21'd10);
    send_request(OP_INSERT, 21'd110, 21'd5);
    send_request(OP_INSERT, 21'd90, 21'd10);
    send_request(OP_LOOKUP, 21'd114, 21'h1FFFFF);
    send_request(OP_LOOKUP, 21'd115, 21'd0);
    for (int k = 0; k < 15; k++) send_request(OP_INSERT, 21'(200 + 4 * k), 21'd2);
    send_request(OP_INSERT, 21'd1000, 21'd1);
    send_request(OP_LOOKUP, 21'd258, 21'd0);
    send_request(OP_INSERT, 21'd0, 21'h1FFFFF);
    send_request(OP_LOOKUP, 21'd300, 21'd0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 46 : 0;
      recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 37 : 0;
      for (int n = 0; n < 400; n++) begin
        // Now and then wipe the table with a whole-space insert so it refills.
        if ($urandom_range(59) == 0) send_request(OP_INSERT, 21'd0, 21'h1FFFFF);
        else send_random();
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb_range_set_insert_lookup: done, clean");
    end else begin
      $display("tb_range_set_insert_lookup: done, errors");
    end
    $finish;
  end

endmodule
